### rtl/core/hdt_pkg.sv
// Shared types, codes and helpers for the heartbeat deadline tracker.
// No dependencies; imported by every module of the block.
package hdt_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned MS_W   = 32;
  // 4294967295 ms * 1e6 stays below 2^52, so a duration never saturates
  localparam int unsigned DUR_W  = 52;
  localparam int unsigned IDX_W  = 2;

  localparam logic [DUR_W-1:0]  NS_PER_MS = DUR_W'(1000000);
  localparam logic [TIME_W-1:0] ALL_ONES  = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_RECV  = 2'd0,
    MODE_PING  = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_WAIT       = 2'd0,
    ACT_SEND_PING  = 2'd1,
    ACT_HB_EXPIRED = 2'd2,
    ACT_RX_EXPIRED = 2'd3
  } action_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PING_INTERVAL  = 2'd0,
    REG_REPLY_TIMEOUT  = 2'd1,
    REG_SILENCE_TIMEOUT = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  // Durations in ns, precomputed from the millisecond registers
  typedef struct packed {
    logic [DUR_W-1:0] ping_period_ns;
    logic [DUR_W-1:0] reply_ns;
    logic [DUR_W-1:0] silence_ns;
    logic             interval_zero;
    logic             reply_zero;
    logic             silence_inf;
  } dur_t;

  // Saturating time + duration; a carry out pins the result at all ones
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DUR_W-1:0]  d);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + (TIME_W+1)'(d);
    return sum[TIME_W] ? ALL_ONES : sum[TIME_W-1:0];
  endfunction

endpackage

### rtl/core/hdt_cfg.sv
// Configuration registers of the heartbeat deadline tracker.
// Scales each millisecond setting to ns at write time. Depends on hdt_pkg.
module hdt_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [hdt_pkg::IDX_W-1:0] cfg_index,
  input  logic [hdt_pkg::MS_W-1:0] cfg_wdata,
  output hdt_pkg::dur_t            dur
);
  import hdt_pkg::*;

  dur_t             dur_r;
  logic [DUR_W-1:0] prod;
  logic             wzero;

  // One 32 x 20 multiply, registered with the setting
  assign prod  = DUR_W'(cfg_wdata) * NS_PER_MS;
  assign wzero = (cfg_wdata == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r.ping_period_ns <= '0;
      dur_r.reply_ns       <= '0;
      dur_r.silence_ns     <= '0;
      dur_r.interval_zero  <= 1'b1;
      dur_r.reply_zero     <= 1'b1;
      dur_r.silence_inf    <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PING_INTERVAL: begin
          dur_r.ping_period_ns <= prod;
          dur_r.interval_zero  <= wzero;
        end
        REG_REPLY_TIMEOUT: begin
          dur_r.reply_ns   <= prod;
          dur_r.reply_zero <= wzero;
        end
        REG_SILENCE_TIMEOUT: begin
          dur_r.silence_ns  <= prod;
          dur_r.silence_inf <= wzero;
        end
        default: ;
      endcase
    end
  end

  assign dur = dur_r;

endmodule

### rtl/core/hdt_eval.sv
// Deadline state and per-event decision logic of the heartbeat tracker.
// Holds the three deadlines; depends on hdt_pkg.
module hdt_eval (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  hdt_pkg::mode_t            mode,
  input  logic [hdt_pkg::TIME_W-1:0] now_ns,
  input  hdt_pkg::dur_t             dur,
  output hdt_pkg::action_t          action,
  output logic [hdt_pkg::TIME_W-1:0] wait_until_ns
);
  import hdt_pkg::*;

  logic [TIME_W-1:0] ping_due_r, ping_due_nxt;
  logic [TIME_W-1:0] reply_due_r, reply_due_nxt;
  logic [TIME_W-1:0] silence_due_r, silence_due_nxt;
  logic [TIME_W-1:0] ping_rearm, reply_arm, silence_rearm;
  logic [TIME_W-1:0] min_pr;

  assign ping_rearm    = sat_add(now_ns, dur.ping_period_ns);
  assign reply_arm     = sat_add(now_ns, dur.reply_ns);
  assign silence_rearm = dur.silence_inf ? ALL_ONES : sat_add(now_ns, dur.silence_ns);

  // Deadline updates for receive and ping events
  always_comb begin
    ping_due_nxt    = ping_due_r;
    reply_due_nxt   = reply_due_r;
    silence_due_nxt = silence_due_r;
    case (mode)
      MODE_RECV: begin
        ping_due_nxt    = ping_rearm;
        reply_due_nxt   = ALL_ONES;
        silence_due_nxt = silence_rearm;
      end
      MODE_PING: begin
        ping_due_nxt = ping_rearm;
        if (reply_due_r == ALL_ONES && !dur.reply_zero) begin
          reply_due_nxt = reply_arm;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_due_r    <= ALL_ONES;
      reply_due_r   <= ALL_ONES;
      silence_due_r <= ALL_ONES;
    end else if (fire) begin
      ping_due_r    <= ping_due_nxt;
      reply_due_r   <= reply_due_nxt;
      silence_due_r <= silence_due_nxt;
    end
  end

  // Check decision in priority order, earliest deadline on wait
  assign min_pr = (reply_due_r < ping_due_r) ? reply_due_r : ping_due_r;

  always_comb begin
    wait_until_ns = '0;
    if (dur.interval_zero) begin
      action = ACT_RX_EXPIRED;
    end else if (reply_due_r <= now_ns) begin
      action = ACT_HB_EXPIRED;
    end else if (silence_due_r <= now_ns) begin
      action = ACT_RX_EXPIRED;
    end else if (ping_due_r <= now_ns) begin
      action = ACT_SEND_PING;
    end else begin
      action        = ACT_WAIT;
      wait_until_ns = (silence_due_r < min_pr) ? silence_due_r : min_pr;
    end
  end

endmodule

### rtl/core/heartbeat_deadline_tracker.sv
// Top level of the heartbeat deadline tracker: input register, decision
// stage and result register. Depends on hdt_pkg, hdt_cfg and hdt_eval.
//
// Keepalive timer holding three ns deadlines (next ping, heartbeat reply,
// receive silence). Each request carries a mode in in_tuser and the current
// time in in_tdata. Receive (0) and ping (1) requests update the deadlines
// and give no result; check (2) requests give one result whose action is in
// out_tuser and, for a wait, the earliest deadline in out_tdata. Mode 3 is
// ignored. A request is registered on acceptance and evaluated from the
// input register into the result register; one request per cycle is taken
// sustained while no check waits on a full result register, combinational
// saturating adds and 64-bit compares setting the rate. Settings are scaled
// to ns by a multiplier at write time and take effect on the next request.
module heartbeat_deadline_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] now_ns
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] wait_until_ns
  output logic [1:0]  out_tuser   // [1:0] action
);
  import hdt_pkg::*;

  dur_t              dur;
  logic              s1_valid_r;
  mode_t             s1_mode_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_is_check, out_free, s1_go;
  action_t           action;
  logic [TIME_W-1:0] wait_until_ns;
  logic              out_valid_r;
  action_t           out_action_r;
  logic [TIME_W-1:0] out_until_r;

  hdt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dur       (dur)
  );

  // Stage handshake: only a check needs room in the result register
  assign s1_is_check = (s1_mode_r == MODE_CHECK);
  assign out_free    = !out_valid_r || out_tready;
  assign s1_go       = s1_valid_r && (!s1_is_check || out_free);
  assign in_tready   = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= mode_t'(in_tuser);
      s1_now_r  <= in_tdata;
    end
  end

  hdt_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_go),
    .mode          (s1_mode_r),
    .now_ns        (s1_now_r),
    .dur           (dur),
    .action        (action),
    .wait_until_ns (wait_until_ns)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_is_check) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_check) begin
      out_action_r <= action;
      out_until_r  <= wait_until_ns;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_until_r;
  assign out_tuser  = out_action_r;

endmodule

### dv/hdt_deadline_checker.sv
// Checker for the heartbeat deadline tracker: mirrors the three deadlines,
// predicts the verdict of every check request and compares it with the
// result channel. Depends on hdt_pkg for the mode, action and register codes.
module hdt_deadline_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] now_ns
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [63:0] wait_until_ns
  input  logic [1:0]  out_tuser,  // [1:0] action
  output int          pending,
  output int          errors,
  output int          n_wait,
  output int          n_ping,
  output int          n_hb,
  output int          n_rx
);
  import hdt_pkg::*;

  localparam logic [63:0] NS_IN_MS = 64'd1000000;

  typedef struct packed {
    action_t     action;
    logic [63:0] wake_at;
  } verdict_t;

  // mirrored settings and deadlines
  logic [31:0] ping_ms, reply_ms, silence_ms;
  logic [63:0] ping_due, reply_due, silence_due;
  verdict_t    due_verdicts[$];
  int          fail_total = 0;
  int          verdict_cnt[4];

  initial begin
    foreach (verdict_cnt[i]) verdict_cnt[i] = 0;
  end

  // 32-bit ms times 1e6 stays below 2^52: never saturates
  function automatic logic [63:0] ms_to_ns(input logic [31:0] ms);
    return 64'(ms) * NS_IN_MS;
  endfunction

  // now plus a duration, pinned at all ones on overflow or infinite duration
  function automatic logic [63:0] deadline_after(input logic [63:0] t,
                                                 input logic [63:0] d);
    logic [64:0] sum;
    sum = {1'b0, t} + {1'b0, d};
    if (d == ALL_ONES || sum[64]) return ALL_ONES;
    return sum[63:0];
  endfunction

  // apply one accepted request to the deadlines; a check queues its verdict
  task automatic advance_deadlines(input mode_t mode, input logic [63:0] now);
    logic [63:0] ping_gap_ns, reply_ns, silence_ns;
    verdict_t    v;
    ping_gap_ns = ms_to_ns(ping_ms);
    reply_ns    = ms_to_ns(reply_ms);
    silence_ns  = (silence_ms == 32'd0) ? ALL_ONES : ms_to_ns(silence_ms);
    v.action    = ACT_WAIT;
    v.wake_at   = 64'd0;
    case (mode)
      MODE_RECV: begin
        ping_due    = deadline_after(now, ping_gap_ns);
        reply_due   = ALL_ONES;
        silence_due = deadline_after(now, silence_ns);
      end
      MODE_PING: begin
        ping_due = deadline_after(now, ping_gap_ns);
        if (reply_due == ALL_ONES && reply_ns != 64'd0)
          reply_due = deadline_after(now, reply_ns);
      end
      MODE_CHECK: begin
        // zero interval always reads as receive expired
        if (ping_gap_ns == 64'd0) v.action = ACT_RX_EXPIRED;
        else if (reply_due <= now) v.action = ACT_HB_EXPIRED;
        else if (silence_due <= now) v.action = ACT_RX_EXPIRED;
        else if (ping_due <= now) v.action = ACT_SEND_PING;
        else begin
          v.wake_at = ping_due;
          if (reply_due < v.wake_at) v.wake_at = reply_due;
          if (silence_due < v.wake_at) v.wake_at = silence_due;
        end
        due_verdicts.push_back(v);
        verdict_cnt[v.action]++;
      end
      default: ;  // mode 3 is ignored
    endcase
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      ping_ms     = 32'd0;
      reply_ms    = 32'd0;
      silence_ms  = 32'd0;
      ping_due    = ALL_ONES;
      reply_due   = ALL_ONES;
      silence_due = ALL_ONES;
      due_verdicts.delete();
    end else begin
      // compare first: a result never belongs to a request of this edge
      if (out_tvalid && out_tready) begin
        if (due_verdicts.size() == 0) begin
          $display("%0t: unexpected result: action %0d wait_until_ns %h",
                   $time, out_tuser, out_tdata);
          fail_total++;
        end else begin
          want = due_verdicts.pop_front();
          if (out_tuser != want.action) begin
            $display("%0t: action expected %0d actual %0d",
                     $time, want.action, out_tuser);
            fail_total++;
          end
          if (out_tdata != want.wake_at) begin
            $display("%0t: wait_until_ns expected %h actual %h",
                     $time, want.wake_at, out_tdata);
            fail_total++;
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PING_INTERVAL:   ping_ms    = cfg_wdata;
          REG_REPLY_TIMEOUT:   reply_ms   = cfg_wdata;
          REG_SILENCE_TIMEOUT: silence_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_deadlines(mode_t'(in_tuser), in_tdata);
    end
    pending <= due_verdicts.size();
    errors  <= fail_total;
    n_wait  <= verdict_cnt[ACT_WAIT];
    n_ping  <= verdict_cnt[ACT_SEND_PING];
    n_hb    <= verdict_cnt[ACT_HB_EXPIRED];
    n_rx    <= verdict_cnt[ACT_RX_EXPIRED];
  end

endmodule

### dv/heartbeat_deadline_tracker_tb.sv
// Testbench top for the heartbeat deadline tracker: clock, reset, request
// stimulus, register settings and the verdict. Depends on hdt_pkg, the
// block and hdt_deadline_checker.
module heartbeat_deadline_tracker_tb;
  import hdt_pkg::*;

  localparam int          N_REQUESTS  = 850;
  localparam int          SETTLE      = 6;
  localparam int          STALL_LIMIT = 2000;
  localparam int          N_PHASES    = 8;
  localparam logic [63:0] NS          = 64'd1000000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [63:0] now_ns
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // [63:0] wait_until_ns
  logic [1:0]  out_tuser;  // [1:0] action

  logic        steady = 1'b0;  // no idling on either side while set
  int          pending, errors, n_wait, n_ping, n_hb, n_rx;
  int          requests_sent = 0;
  int          stall_cycles = 0;
  logic [63:0] clock_ns;
  logic [31:0] ping_ms, reply_ms, silence_ms;

  always #1 clk = ~clk;

  heartbeat_deadline_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  hdt_deadline_checker deadline_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .pending    (pending),
    .errors     (errors),
    .n_wait     (n_wait),
    .n_ping     (n_ping),
    .n_hb       (n_hb),
    .n_rx       (n_rx)
  );

  // result side back-pressure
  always @(posedge clk) out_tready <= steady || ($urandom_range(99) >= 31);

  // watchdog: cycles without any accepted request, result or write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one request, with a random idle gap ahead of it
  task automatic send_request(input mode_t mode, input logic [63:0] now);
    if (!steady && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 31) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= now;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode != MODE_NONE) requests_sent++;
  endtask

  // stop requests, wait out every result plus the pipeline tail
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] p, input logic [31:0] r,
                             input logic [31:0] s, input bit spare);
    drain();
    write_reg(REG_PING_INTERVAL, p);
    write_reg(REG_REPLY_TIMEOUT, r);
    write_reg(REG_SILENCE_TIMEOUT, s);
    if (spare) write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    ping_ms    = p;
    reply_ms   = r;
    silence_ms = s;
    // let the ms-to-ns scaling settle
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly well-formed traffic on a rising clock, some noise mixed in
  task automatic run_traffic(input int count);
    int          done;
    int          pick;
    mode_t       mode;
    logic [63:0] scale;
    logic [63:0] step;
    logic [63:0] t;
    // time steps follow the shortest armed duration
    scale = ALL_ONES;
    if (ping_ms != 0 && 64'(ping_ms) * NS < scale) scale = 64'(ping_ms) * NS;
    if (reply_ms != 0 && 64'(reply_ms) * NS < scale) scale = 64'(reply_ms) * NS;
    if (silence_ms != 0 && 64'(silence_ms) * NS < scale) scale = 64'(silence_ms) * NS;
    if (scale == ALL_ONES) scale = NS;
    send_request(MODE_RECV, clock_ns);
    done = 1;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_request(MODE_NONE, {$urandom, $urandom});
      end else if (pick < 9) begin
        // times out of order: anywhere, or close to the top of the range
        if ($urandom_range(1) == 0) t = {$urandom, $urandom};
        else t = ALL_ONES - 64'($urandom_range(2000));
        send_request(mode_t'($urandom_range(2)), t);
        done++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 10) step = 64'd0;
        else if (pick < 25) begin
          // land exactly on a deadline
          case ($urandom_range(2))
            0:       step = 64'(ping_ms) * NS;
            1:       step = 64'(reply_ms) * NS;
            default: step = 64'(silence_ms) * NS;
          endcase
        end else step = scale * 64'($urandom_range(150)) / 64'd100;
        clock_ns = clock_ns + step;
        pick = $urandom_range(99);
        mode = (pick < 15) ? MODE_RECV : (pick < 45) ? MODE_PING : MODE_CHECK;
        send_request(mode, clock_ns);
        done++;
      end
    end
  endtask

  initial begin
    int ph;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PING_INTERVAL;
    cfg_wdata <= 32'd0;
    in_tvalid <= 1'b0;
    in_tdata  <= 64'd0;
    in_tuser  <= MODE_RECV;
    ping_ms    = 32'd0;
    reply_ms   = 32'd0;
    silence_ms = 32'd0;
    clock_ns   = 64'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero interval, reply never armed, no silence limit
    send_request(MODE_CHECK, 64'd0);
    send_request(MODE_RECV, 64'd100);
    send_request(MODE_PING, 64'd200);
    send_request(MODE_CHECK, ALL_ONES);

    // 5 ms ping, 3 ms reply, 20 ms silence: walk through every verdict
    reconfigure(32'd5, 32'd3, 32'd20, 1'b0);
    send_request(MODE_CHECK, 64'd0);
    send_request(MODE_RECV, 64'd1000);
    send_request(MODE_CHECK, 64'd1000);
    send_request(MODE_CHECK, 64'd5001000);
    send_request(MODE_PING, 64'd5001000);
    send_request(MODE_CHECK, 64'd7000000);
    send_request(MODE_CHECK, 64'd8001000);
    send_request(MODE_RECV, 64'd8500000);
    send_request(MODE_PING, 64'd9000000);
    send_request(MODE_PING, 64'd9500000);
    // reply and silence both past: heartbeat wins
    send_request(MODE_CHECK, 64'd30000000);
    send_request(MODE_RECV, 64'd30000000);
    // silence and ping both past: receive wins
    send_request(MODE_CHECK, 64'd50000000);
    send_request(MODE_NONE, ALL_ONES);
    // saturated deadlines near the end of time
    send_request(MODE_RECV, ALL_ONES - 64'd100);
    send_request(MODE_CHECK, ALL_ONES - 64'd50);
    send_request(MODE_CHECK, ALL_ONES);

    // largest settings, silence unlimited, spare index written too
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_request(MODE_RECV, 64'd0);
    send_request(MODE_PING, 64'd1);
    send_request(MODE_CHECK, 64'h0000_8000_0000_0000);
    send_request(MODE_CHECK, 64'hF0F0_0000_0000_0000);

    // random phases over a spread of settings
    clock_ns = 64'd1000000000;
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: reconfigure($urandom_range(1, 12), $urandom_range(1, 12),
                       $urandom_range(1, 12), 1'b0);
        1: reconfigure(32'd0, $urandom_range(1, 12), $urandom_range(1, 12), 1'b0);
        2: reconfigure($urandom_range(1, 12), 32'd0, $urandom_range(1, 12), 1'b0);
        3: reconfigure($urandom_range(1, 12), $urandom_range(1, 12), 32'd0, 1'b0);
        4: reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        5: reconfigure($urandom, $urandom, $urandom, 1'b1);
        6: reconfigure(32'd1, 32'd1, 32'd1, 1'b0);
        default: reconfigure($urandom_range(1, 12), $urandom_range(1, 12),
                             $urandom_range(4, 48), 1'b0);
      endcase
      // one phase runs with no idling at all
      steady <= (ph == 3);
      run_traffic((N_REQUESTS - requests_sent) / (N_PHASES - ph));
    end
    steady <= 1'b0;

    drain();
    $display("Ran %0d receive, ping and check requests over %0d register settings",
             requests_sent, N_PHASES + 3);
    $display("Verdicts: %0d wait, %0d send ping, %0d heartbeat expired, %0d receive expired",
             n_wait, n_ping, n_hb, n_rx);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
